[hw/rtl/mnlp_pkg.sv]
package mnlp_pkg;

    localparam int NUM_KEYS    = 128;
    localparam int STAMP_WIDTH = 32;
    localparam int COUNT_W     = 32;
    localparam int NOTE_W      = 7;
    localparam int KEY_AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EXT_W       = (STAMP_WIDTH > COUNT_W) ? STAMP_WIDTH : COUNT_W;

    // command queue between parser and stamp table
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;

    // byte codes
    localparam logic [7:0] BYTE_RT_FF  = 8'hFF;
    localparam logic [7:0] BYTE_RT_FE  = 8'hFE;
    localparam logic [7:0] STATUS_MASK = 8'hF0;
    localparam logic [7:0] STATUS_ON   = 8'h90;
    localparam logic [7:0] STATUS_OFF  = 8'h80;
    localparam logic [7:0] VEL_ZERO    = 8'h00;

    // parser modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    typedef struct packed {
        logic                   wr;
        logic [KEY_AW-1:0]      key;
        logic [STAMP_WIDTH-1:0] stamp;
        logic [COUNT_W-1:0]     count;
        logic                   ev;
    } cmd_t;

    function automatic logic [STAMP_WIDTH-1:0] to_stamp(input logic [COUNT_W-1:0] cnt);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(cnt);
        return ext[STAMP_WIDTH-1:0];
    endfunction

endpackage

[hw/rtl/mnlp_ram.sv]
module mnlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/mnlp_parser.sv]
module mnlp_parser import mnlp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] midi_byte,
    output cmd_t       cmd
);

    logic [1:0]         mode_reg, mode_next;
    logic [1:0]         bas_reg, bas_next;
    logic [NOTE_W-1:0]  note_reg, note_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               ev;
    logic               clear;
    logic               is_rt;

    assign is_rt = (midi_byte == BYTE_RT_FF) || (midi_byte == BYTE_RT_FE);

    always_comb
    begin
        mode_next = mode_reg;
        bas_next  = bas_reg;
        note_next = note_reg;
        cnt_next  = cnt_reg;
        ev        = 1'b0;
        clear     = 1'b0;
        if (accept && !is_rt)
        begin
            priority if (mode_reg == MODE_ON || mode_reg == MODE_OFF)
            begin
                bas_next = bas_reg + 2'd1;
                if (bas_next == 2'd1)
                begin
                    note_next = midi_byte[NOTE_W-1:0];
                end
                else
                begin
                    cnt_next  = cnt_reg + COUNT_W'(1);
                    ev        = 1'b1;
                    clear     = (mode_reg == MODE_OFF) || (midi_byte == VEL_ZERO);
                    mode_next = MODE_IDLE;
                    bas_next  = 2'd0;
                end
            end
            else if ((midi_byte & STATUS_MASK) == STATUS_ON)
            begin
                mode_next = MODE_ON;
                bas_next  = 2'd0;
            end
            else if ((midi_byte & STATUS_MASK) == STATUS_OFF)
            begin
                mode_next = MODE_OFF;
                bas_next  = 2'd0;
            end
        end
    end

    // every accepted byte yields one request, event or not
    always_comb
    begin
        cmd.ev    = ev;
        cmd.count = cnt_next;
        cmd.key   = note_reg[KEY_AW-1:0];
        cmd.wr    = ev && (32'(note_reg) < NUM_KEYS);
        cmd.stamp = clear ? '0 : to_stamp(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            bas_reg  <= 2'd0;
            note_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            bas_reg  <= bas_next;
            note_reg <= note_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[hw/rtl/mnlp_cmd_fifo.sv]
module mnlp_cmd_fifo import mnlp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic empty,
    output cmd_t rd_data
);

    cmd_t             slot_reg [CQ_DEPTH];
    logic [CQ_AW-1:0] wptr_reg, wptr_next;
    logic [CQ_AW-1:0] rptr_reg, rptr_next;
    logic [CQ_AW:0]   level_reg, level_next;
    logic             do_wr, do_rd;

    assign full    = (level_reg == (CQ_AW+1)'(CQ_DEPTH));
    assign empty   = (level_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        level_next = level_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wptr_reg + CQ_AW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rptr_reg + CQ_AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            level_next = level_reg + (CQ_AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            level_next = level_reg - (CQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
        end
    end

endmodule

[hw/rtl/mnlp_scan.sv]
module mnlp_scan import mnlp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cmd_t               q_head,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [6:0]         recent_key,
    output logic               key_held,
    output logic [COUNT_W-1:0] event_count,
    output logic               note_event
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [KEY_AW-1:0] LAST_KEY = KEY_AW'(NUM_KEYS - 1);

    logic [1:0]             state_reg, state_next;
    logic [KEY_AW-1:0]      idx_reg, idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [KEY_AW-1:0]      cmp_key_reg, cmp_key_next;
    logic                   vbit_rd_reg, vbit_rd_next;
    logic [STAMP_WIDTH-1:0] run_best_reg, run_best_next;
    logic [KEY_AW-1:0]      run_key_reg, run_key_next;
    logic [STAMP_WIDTH-1:0] best_val_reg, best_val_next;
    logic [KEY_AW-1:0]      best_key_reg, best_key_next;
    logic [COUNT_W-1:0]     cur_count_reg, cur_count_next;
    logic                   cur_ev_reg, cur_ev_next;
    logic [NUM_KEYS-1:0]    valid_reg, valid_next;

    logic                   out_valid_reg, out_valid_next;
    logic [6:0]             out_key_reg, out_key_next;
    logic                   out_held_reg, out_held_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                   out_ev_reg, out_ev_next;

    logic                   start;
    logic                   ram_we;
    logic                   ram_re;
    logic [STAMP_WIDTH-1:0] ram_rdata;
    logic [STAMP_WIDTH-1:0] cand;
    logic                   better;

    assign start = (state_reg == ST_IDLE) && !q_empty && (!out_valid_reg || pop);
    assign q_pop = start;
    assign ram_we = start && q_head.wr;
    assign ram_re = (state_reg == ST_SCAN);

    mnlp_ram #(
        .WIDTH (STAMP_WIDTH),
        .DEPTH (NUM_KEYS)
    ) u_stamps (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_head.key),
        .wdata (q_head.stamp),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // never-written entries read as zero stamp
    assign cand   = vbit_rd_reg ? ram_rdata : '0;
    assign better = cmp_vld_reg && (cand > run_best_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_key_next   = idx_reg;
        vbit_rd_next   = valid_reg[idx_reg];
        run_best_next  = better ? cand : run_best_reg;
        run_key_next   = better ? cmp_key_reg : run_key_reg;
        best_val_next  = best_val_reg;
        best_key_next  = best_key_reg;
        cur_count_next = cur_count_reg;
        cur_ev_next    = cur_ev_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !pop;
        out_key_next   = out_key_reg;
        out_held_next  = out_held_reg;
        out_count_next = out_count_reg;
        out_ev_next    = out_ev_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cur_count_next = q_head.count;
                    cur_ev_next    = q_head.ev;
                    if (q_head.wr)
                    begin
                        valid_next[q_head.key] = 1'b1;
                        idx_next      = '0;
                        run_best_next = '0;
                        run_key_next  = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        // table unchanged, previous winner stands
                        out_valid_next = 1'b1;
                        out_key_next   = 7'(best_key_reg);
                        out_held_next  = (best_val_reg != '0);
                        out_count_next = q_head.count;
                        out_ev_next    = q_head.ev;
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                if (idx_reg == LAST_KEY)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + KEY_AW'(1);
                end
            end
            ST_DRAIN:
            begin
                best_val_next  = run_best_next;
                best_key_next  = run_key_next;
                out_valid_next = 1'b1;
                out_key_next   = 7'(run_key_next);
                out_held_next  = (run_best_next != '0);
                out_count_next = cur_count_reg;
                out_ev_next    = cur_ev_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            best_val_reg  <= '0;
            best_key_reg  <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            best_val_reg  <= best_val_next;
            best_key_reg  <= best_key_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_key_reg   <= cmp_key_next;
        vbit_rd_reg   <= vbit_rd_next;
        run_best_reg  <= run_best_next;
        run_key_reg   <= run_key_next;
        cur_count_reg <= cur_count_next;
        cur_ev_reg    <= cur_ev_next;
        out_key_reg   <= out_key_next;
        out_held_reg  <= out_held_next;
        out_count_reg <= out_count_next;
        out_ev_reg    <= out_ev_next;
    end

    assign empty       = !out_valid_reg;
    assign recent_key  = out_key_reg;
    assign key_held    = out_held_reg;
    assign event_count = out_count_reg;
    assign note_event  = out_ev_reg;

endmodule

[hw/rtl/midi_note_last_priority.sv]
// MIDI note parser with last-note priority. Each raw byte pushed in gives exactly one result,
// in order: the held key with the newest stamp (lowest key on a tie, 0 when none), whether any
// key is held, the running event count and whether this byte completed a note event. The
// parser takes a byte every cycle while its two-entry request queue has room. A byte that does
// not change the stamp table goes straight to the result register; a byte that completes a note
// event costs a full scan there (one write, one read a cycle through the stamp RAM for every
// key, one final compare), and the back end takes no new request until the scan is done. The
// stamp RAM has a single read port, so the keys are read one at a time. The stamp table reads
// as all zero right after reset through per-key valid bits, so no clearing pass is needed.
module midi_note_last_priority import mnlp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         midi_byte,
    output logic               empty,
    input  logic               pop,
    output logic [6:0]         recent_key,
    output logic               key_held,
    output logic [COUNT_W-1:0] event_count,
    output logic               note_event
);

    cmd_t parse_cmd;
    cmd_t q_head;
    logic accept;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    mnlp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .midi_byte (midi_byte),
        .cmd       (parse_cmd)
    );

    mnlp_cmd_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (parse_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .rd_data (q_head)
    );

    mnlp_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .recent_key  (recent_key),
        .key_held    (key_held),
        .event_count (event_count),
        .note_event  (note_event)
    );

    // back end only takes a request that is there
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("request taken from empty queue");

    // with nothing held the reported key is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !key_held) |-> (recent_key == 7'd0))
        else $error("key reported while none held");

    // a request is only taken while the result slot is free or being drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !empty) |-> pop)
        else $error("result overwritten");

endmodule

[test/mnlp_note_checker.sv]
module mnlp_note_checker
    import mnlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [7:0]         midi_byte,
    input  logic               empty,
    input  logic               pop,
    input  logic [6:0]         recent_key,
    input  logic               key_held,
    input  logic [COUNT_W-1:0] event_count,
    input  logic               note_event,
    output int                 mismatches,
    output int                 results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0]         key;
        logic               held;
        logic [COUNT_W-1:0] count;
        logic               ev;
    } key_report_t;

    // local copy of the parser and the stamp table
    logic [1:0]             rx_mode;
    logic [1:0]             data_taken;
    logic [NOTE_W-1:0]      note_num;
    logic [STAMP_WIDTH-1:0] stamp_of [NUM_KEYS];
    logic [COUNT_W-1:0]     events_seen;
    key_report_t            reports_due [$];
    key_report_t            want;

    initial
    begin
        mismatches  = 0;
        results_due = 0;
    end

    task automatic flag_error(input string msg);
        mismatches++;
        $display("[%0t] checker: %s", $time, msg);
    endtask

    // advance the parser by one byte and work out the report it causes
    function automatic key_report_t track_byte(input logic [7:0] b);
        key_report_t            r;
        logic [STAMP_WIDTH-1:0] best;
        r    = '0;
        best = '0;
        if (b != BYTE_RT_FF && b != BYTE_RT_FE)
        begin
            if (rx_mode == MODE_ON || rx_mode == MODE_OFF)
            begin
                data_taken = data_taken + 2'd1;
                if (data_taken == 2'd1)
                    note_num = b[NOTE_W-1:0];
                else
                begin
                    events_seen = events_seen + 1'b1;
                    if (int'(note_num) < NUM_KEYS)
                        stamp_of[note_num] = (rx_mode == MODE_OFF || b == VEL_ZERO) ?
                                             '0 : STAMP_WIDTH'(events_seen);
                    rx_mode    = MODE_IDLE;
                    data_taken = '0;
                    r.ev       = 1'b1;
                end
            end
            else if ((b & STATUS_MASK) == STATUS_ON)
            begin
                rx_mode    = MODE_ON;
                data_taken = '0;
            end
            else if ((b & STATUS_MASK) == STATUS_OFF)
            begin
                rx_mode    = MODE_OFF;
                data_taken = '0;
            end
        end
        // strict compare keeps the lowest key on a tie
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (stamp_of[k] > best)
            begin
                best  = stamp_of[k];
                r.key = 7'(k);
            end
        end
        r.held  = (best != '0);
        r.count = events_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_mode     = MODE_IDLE;
            data_taken  = '0;
            note_num    = '0;
            events_seen = '0;
            for (int k = 0; k < NUM_KEYS; k++)
                stamp_of[k] = '0;
            reports_due.delete();
            results_due = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (reports_due.size() == 0)
                    flag_error($sformatf("result with no request pending (count %0d)",
                                         event_count));
                else
                begin
                    want = reports_due.pop_front();
                    if (recent_key !== want.key)
                        flag_error($sformatf("recent_key %0d, expected %0d (count %0d)",
                                             recent_key, want.key, want.count));
                    if (key_held !== want.held)
                        flag_error($sformatf("key_held %0b, expected %0b (count %0d)",
                                             key_held, want.held, want.count));
                    if (event_count !== want.count)
                        flag_error($sformatf("event_count %0d, expected %0d",
                                             event_count, want.count));
                    if (note_event !== want.ev)
                        flag_error($sformatf("note_event %0b, expected %0b (count %0d)",
                                             note_event, want.ev, want.count));
                end
            end
            if (push && !full)
                reports_due.push_back(track_byte(midi_byte));
            results_due = reports_due.size();
        end
    end

endmodule

[test/tb_midi_note_last_priority.sv]
module tb_midi_note_last_priority import mnlp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1500;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         midi_byte;
    logic               empty;
    logic               pop;
    logic [6:0]         recent_key;
    logic               key_held;
    logic [COUNT_W-1:0] event_count;
    logic               note_event;

    int mismatches;
    int results_due;
    int bytes_sent   = 0;
    int cycle_count  = 0;
    bit tx_gaps      = 1'b1;
    bit rx_gaps      = 1'b1;
    bit hold_results = 1'b0;

    midi_note_last_priority u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .midi_byte   (midi_byte),
        .empty       (empty),
        .pop         (pop),
        .recent_key  (recent_key),
        .key_held    (key_held),
        .event_count (event_count),
        .note_event  (note_event)
    );

    mnlp_note_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .midi_byte   (midi_byte),
        .empty       (empty),
        .pop         (pop),
        .recent_key  (recent_key),
        .key_held    (key_held),
        .event_count (event_count),
        .note_event  (note_event),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** midi_note_last_priority: FAILED **");
        $finish;
    end

    // result side: pop in random runs, random stalls, one long hold-off on request
    initial
    begin
        pop = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        push      <= 1'b1;
        midi_byte <= b;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
        if (tx_gaps && $urandom_range(0, 9) == 0)
        begin
            push      <= 1'b0;
            midi_byte <= 8'($urandom);
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic maybe_realtime();
        if ($urandom_range(0, 11) == 0)
            send_byte($urandom_range(0, 1) ? BYTE_RT_FF : BYTE_RT_FE);
    endtask

    // one note on/off message with random content, sometimes cut short
    task automatic send_note_message();
        logic [7:0] status;
        logic [7:0] note_b;
        logic [7:0] vel_b;
        int         parts;
        status = (($urandom_range(0, 3) != 0) ? STATUS_ON : STATUS_OFF) |
                 8'($urandom_range(0, 15));
        // mostly a narrow key range so keys get pressed and released often
        note_b = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(56, 71)) :
                                              8'($urandom_range(0, 255));
        vel_b  = ($urandom_range(0, 4) == 0) ? VEL_ZERO : 8'($urandom_range(0, 255));
        parts  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 3;
        send_byte(status);
        maybe_realtime();
        if (parts > 1)
        begin
            send_byte(note_b);
            maybe_realtime();
        end
        if (parts > 2)
            send_byte(vel_b);
    endtask

    task automatic send_directed();
        logic [7:0] seq [$];
        seq = '{BYTE_RT_FF, BYTE_RT_FE, 8'h00, 8'h7F, 8'hF0,
                STATUS_ON, 8'h00, 8'h7F,
                STATUS_ON | 8'h0F, 8'h7F, 8'h01,
                // real-time bytes inside a message
                STATUS_ON | 8'h05, BYTE_RT_FE, 8'h3C, BYTE_RT_FF, 8'h64,
                // status bytes in data positions are data, note masked to 5
                STATUS_ON, STATUS_OFF | 8'h05, 8'hF0,
                // no running status: these two are dropped
                8'h40, 8'h40,
                STATUS_ON | 8'h03, 8'h7F, VEL_ZERO,
                STATUS_OFF | 8'h0F, 8'h85, 8'h40};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
    endtask

    initial
    begin
        bit held_once;
        bit paused_once;
        held_once   = 1'b0;
        paused_once = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        midi_byte   = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        while (bytes_sent < ITEM_TARGET)
        begin
            if (!held_once && bytes_sent >= 600)
            begin
                // receiver holds off while the sender keeps pushing
                held_once    = 1'b1;
                hold_results = 1'b1;
                tx_gaps      = 1'b0;
                repeat (20) send_note_message();
                tx_gaps      = 1'b1;
            end
            else if (!paused_once && bytes_sent >= 1000)
            begin
                paused_once = 1'b1;
                wait_all_results();
            end
            else
            begin
                if (bytes_sent >= 1300)
                begin
                    tx_gaps = 1'b0;
                    rx_gaps = 1'b0;
                end
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom));
                else
                    send_note_message();
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due == 0)
            $display("** midi_note_last_priority: PASSED **");
        else
            $display("** midi_note_last_priority: FAILED **");
        $finish;
    end

endmodule
